// ===== rtl/bmaa_pkg.sv =====
// ----------------------------------------------------------------------------
// bmaa_pkg
// Shared constants, codes and types of the bitmap aligned allocator.
// ----------------------------------------------------------------------------
package bmaa_pkg;

    localparam int HEAP_UNITS    = 4096;
    localparam int MAX_RUN       = 1024;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = (HEAP_UNITS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

    localparam int UNIT_W     = $clog2(HEAP_UNITS);      // unit offset
    localparam int PTR_W      = UNIT_W + 1;              // offset up to HEAP_UNITS
    localparam int BIT_IDX_W  = $clog2(MAP_WORD_BITS);
    localparam int WORD_IDX_W = $clog2(MAP_WORDS);
    localparam int CNT_W      = 11;
    localparam int ALIGN_W    = 4;
    localparam int STATUS_W   = 2;
    // candidate offset: (0 + 1) << 15 is the largest value the skip step makes
    localparam int OFF_W      = (1 << ALIGN_W) + 1;
    localparam int SUM_W      = OFF_W + 1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [MAP_WORD_BITS-1:0] map_word_t;

    // result of examining one map word over the range [p, e)
    typedef struct packed {
        map_word_t            mask;       // bits of the range inside this word
        logic                 hit;        // a used unit inside the range
        logic [BIT_IDX_W-1:0] first;      // lowest used bit in the range
        logic                 last_word;  // range ends inside this word
        logic [PTR_W-1:0]     next_p;     // first unit of the following word
    } word_res_t;

endpackage

// ===== rtl/bmaa_ram.sv =====
// ----------------------------------------------------------------------------
// bmaa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmaa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bmaa_word_unit.sv =====
// ----------------------------------------------------------------------------
// bmaa_word_unit
// Shared word examiner: range mask, first used unit, end-of-range test.
// ----------------------------------------------------------------------------
module bmaa_word_unit (
    input  bmaa_pkg::map_word_t         word,
    input  logic [bmaa_pkg::PTR_W-1:0]  p,
    input  logic [bmaa_pkg::PTR_W-1:0]  e,
    output bmaa_pkg::word_res_t         res
);
    import bmaa_pkg::*;

    logic [WORD_IDX_W:0] nb;
    logic [PTR_W-1:0]    boundary;
    map_word_t           lo_mask;
    map_word_t           hi_mask;
    map_word_t           used;
    map_word_t           lowest;
    logic [BIT_IDX_W-1:0] first;

    always_comb begin
        nb       = {1'b0, p[PTR_W-2:BIT_IDX_W]} + 1'b1;
        boundary = {nb, {BIT_IDX_W{1'b0}}};
        res.last_word = (e <= boundary);
        res.next_p    = boundary;

        lo_mask = '1 << p[BIT_IDX_W-1:0];
        if (res.last_word && (e[BIT_IDX_W-1:0] != '0)) begin
            hi_mask = ~('1 << e[BIT_IDX_W-1:0]);
        end else begin
            hi_mask = '1;
        end
        res.mask = lo_mask & hi_mask;

        used    = word & res.mask;
        res.hit = (used != '0);
        // isolate the lowest set bit, then encode it
        lowest  = used & (~used + 1'b1);
        first   = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++) begin
            if (lowest[i]) begin
                first = first | BIT_IDX_W'(i);
            end
        end
        res.first = first;
    end

endmodule

// ===== rtl/bitmap_aligned_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_aligned_allocator_core
// First-fit aligned run allocator over a 4096-unit used-map.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream (s_tuser carries the command: allocate or
//   free); one result item leaves on the m_ stream per request, in order.
//   The used-map sits in a 64 x 64-bit RAM; one shared word examiner checks
//   or updates one map word at a time, in two steps (RAM read, then evaluate/write).
//   Each item runs from the accepting cycle through a check step: a bad count
//   or bad range goes straight to the finish step and the result register;
//   a free reads and writes each map word it touches; an allocate tests
//   candidate offsets (including the final one that runs past the heap),
//   scans map words for each candidate and then reads and writes each word
//   of the granted run.
//   The block takes one item at a time: s_tready is high only while idle.
//   A result waits in the output register while the receiver stalls; the
//   block stays in its finish step until the previous result is taken.
//   Reset clears control state and the per-word valid bits, so the whole map
//   reads as free at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_aligned_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // unit_count[10:0], align_log2[14:11],
                                   // free_offset[26:15], zero pad [31:27]
    input  logic [0:0]  s_tuser,   // cmd[0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], granted_offset[13:2],
                                   // zero pad [15:14]
);
    import bmaa_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_CAND    = 3'd2;  // test candidate offset
    localparam logic [2:0] S_SCAN_RD = 3'd3;
    localparam logic [2:0] S_SCAN_EV = 3'd4;
    localparam logic [2:0] S_UPD_RD  = 3'd5;
    localparam logic [2:0] S_UPD_WR  = 3'd6;
    localparam logic [2:0] S_FIN     = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic                cmd_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ALIGN_W-1:0]  align_reg;
    logic [UNIT_W-1:0]   foff_reg;
    logic [OFF_W-1:0]    off_reg, off_next;      // current candidate start
    logic [PTR_W-1:0]    p_reg, p_next;          // scan / update pointer
    logic [PTR_W-1:0]    end_reg, end_next;      // end of run, exclusive
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [UNIT_W-1:0]   grant_reg, grant_next;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [UNIT_W-1:0]   m_grant_reg;

    // per-word valid bits: a word never written reads as all free
    logic [MAP_WORDS-1:0] valid_reg;
    logic                 rd_valid_reg;

    logic                  ram_we;
    logic [WORD_IDX_W-1:0] ram_addr;
    map_word_t             ram_q;
    map_word_t             ram_wdata;
    map_word_t             word;
    word_res_t             wres;

    logic [SUM_W-1:0]  cand_sum;
    logic [PTR_W-1:0]  free_sum;
    logic [OFF_W-1:0]  used_unit;
    logic [OFF_W-1:0]  skip_off;
    logic              in_acc;
    logic              cnt_bad;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_grant_reg, m_status_reg};

    assign ram_addr  = p_reg[PTR_W-2:BIT_IDX_W];
    assign word      = rd_valid_reg ? ram_q : '0;
    assign ram_we    = (state_reg == S_UPD_WR);
    assign ram_wdata = (cmd_reg == CMD_ALLOC) ? (word | wres.mask) : (word & ~wres.mask);

    bmaa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_q)
    );

    bmaa_word_unit u_word (
        .word (word),
        .p    (p_reg),
        .e    (end_reg),
        .res  (wres)
    );

    assign cnt_bad  = (cnt_reg == '0) || (cnt_reg > CNT_W'(MAX_RUN));
    assign cand_sum = {1'b0, off_reg} + SUM_W'(cnt_reg);
    assign free_sum = {1'b0, foff_reg} + PTR_W'(cnt_reg);
    // skip to the next aligned offset past the used unit
    assign used_unit = OFF_W'({p_reg[PTR_W-2:BIT_IDX_W], wres.first});
    assign skip_off  = ((used_unit >> align_reg) + 1'b1) << align_reg;

    always_comb begin
        state_next  = state_reg;
        off_next    = off_reg;
        p_next      = p_reg;
        end_next    = end_reg;
        status_next = status_reg;
        grant_next  = grant_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                status_next = ST_OK;
                grant_next  = '0;
                off_next    = '0;
                if (cnt_bad) begin
                    status_next = ST_BAD;
                    state_next  = S_FIN;
                end else if (cmd_reg == CMD_FREE) begin
                    if ({1'b0, free_sum} > (PTR_W + 1)'(HEAP_UNITS) ||
                        free_sum < {1'b0, foff_reg}) begin
                        status_next = ST_BAD;
                        state_next  = S_FIN;
                    end else begin
                        p_next     = {1'b0, foff_reg};
                        end_next   = free_sum;
                        state_next = S_UPD_RD;
                    end
                end else begin
                    state_next = S_CAND;
                end
            end
            S_CAND: begin
                if (cand_sum > SUM_W'(HEAP_UNITS)) begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_FIN;
                end else begin
                    p_next     = off_reg[PTR_W-1:0];
                    end_next   = cand_sum[PTR_W-1:0];
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                priority if (wres.hit) begin
                    off_next   = skip_off;
                    state_next = S_CAND;
                end else if (wres.last_word) begin
                    p_next     = off_reg[PTR_W-1:0];
                    state_next = S_UPD_RD;
                end else begin
                    p_next     = wres.next_p;
                    state_next = S_SCAN_RD;
                end
            end
            S_UPD_RD: begin
                state_next = S_UPD_WR;
            end
            S_UPD_WR: begin
                if (wres.last_word) begin
                    grant_next = (cmd_reg == CMD_ALLOC) ? off_reg[UNIT_W-1:0] : '0;
                    state_next = S_FIN;
                end else begin
                    p_next     = wres.next_p;
                    state_next = S_UPD_RD;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (ram_we) begin
                valid_reg[ram_addr] <= 1'b1;
            end
            if (state_reg == S_FIN && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cmd_reg   <= s_tuser[0];
            cnt_reg   <= s_tdata[10:0];
            align_reg <= s_tdata[14:11];
            foff_reg  <= s_tdata[26:15];
        end
        off_reg      <= off_next;
        p_reg        <= p_next;
        end_reg      <= end_next;
        status_reg   <= status_next;
        grant_reg    <= grant_next;
        rd_valid_reg <= valid_reg[ram_addr];
        if (state_reg == S_FIN && (!m_valid_reg || m_tready)) begin
            m_status_reg <= status_reg;
            m_grant_reg  <= grant_reg;
        end
    end

    // a failed request never reports an offset, for allocates and frees alike
    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status_reg != ST_OK) |-> (m_grant_reg == '0))
        else $error("nonzero offset on failed request");

    // status code is always one of the three defined results
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_status_reg == ST_OK || m_status_reg == ST_NO_SPACE ||
                      m_status_reg == ST_BAD))
        else $error("undefined status code");

    // the scan pointer stays inside the run being examined
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN_EV || state_reg == S_UPD_WR) |->
            (p_reg < end_reg && end_reg <= PTR_W'(HEAP_UNITS)))
        else $error("scan pointer outside run");

    // a request is not taken again until the current one finishes
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("second request taken while busy");

endmodule

// ===== bench/bmaa_grant_checker.sv =====
// ----------------------------------------------------------------------------
// bmaa_grant_checker
// Watches both streams of the allocator, keeps its own used-map, predicts the
// result of every accepted request and compares it with the result item.
// ----------------------------------------------------------------------------
module bmaa_grant_checker
    import bmaa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // unit_count[10:0], align_log2[14:11],
                                   // free_offset[26:15], zero pad [31:27]
    input  logic [0:0]  s_tuser,   // cmd[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // status[1:0], granted_offset[13:2],
                                   // zero pad [15:14]
    output int          mismatch_count,
    output int          grants_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [UNIT_W-1:0]   offset;
    } grant_t;

    logic [HEAP_UNITS-1:0] unit_busy;       // 1 = unit in use
    grant_t                expected_grants[$];
    int                    errs = 0;

    // Serve one request against the shadow map; returns the result it gives.
    function automatic grant_t predict_grant(input logic                cmd,
                                             input logic [CNT_W-1:0]   cnt,
                                             input logic [ALIGN_W-1:0] align,
                                             input logic [UNIT_W-1:0]  foff);
        grant_t                g;
        longint unsigned       off;
        longint unsigned       p;
        longint unsigned       stop;
        bit                    found;
        int                    i;
        g.status = ST_OK;
        g.offset = '0;
        off      = 0;
        found    = 1'b0;
        if (cnt == 0 || cnt > MAX_RUN) begin
            g.status = ST_BAD;
        end else if (cmd == CMD_FREE) begin
            if (foff + cnt > HEAP_UNITS) begin
                g.status = ST_BAD;
            end else begin
                for (i = 0; i < cnt; i++) unit_busy[foff + i] = 1'b0;
            end
        end else begin
            // first fit: on a used unit, jump to the next aligned offset past it
            while (!found && off + cnt <= HEAP_UNITS) begin
                p    = off;
                stop = off + cnt;
                while (p < stop && !unit_busy[p]) p++;
                if (p == stop) begin
                    found = 1'b1;
                end else begin
                    off = ((p >> align) + 1) << align;
                end
            end
            if (found) begin
                for (i = 0; i < cnt; i++) unit_busy[off + i] = 1'b1;
                g.offset = off[UNIT_W-1:0];
            end else begin
                g.status = ST_NO_SPACE;
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin
        grant_t want;
        grant_t got;
        if (!aresetn) begin
            unit_busy = '0;
            expected_grants.delete();
        end else begin
            // results first: a result on this edge never belongs to a request
            // accepted on the same edge
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[STATUS_W-1:0];
                got.offset = m_tdata[STATUS_W+UNIT_W-1:STATUS_W];
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected result item, status %0d offset %0d",
                             $time, got.status, got.offset);
                    errs++;
                end else begin
                    want = expected_grants.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errs++;
                    end
                    if (got.offset !== want.offset) begin
                        $display("%0t: granted_offset expected %0d actual %0d",
                                 $time, want.offset, got.offset);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_grants.push_back(predict_grant(
                    s_tuser[0],
                    s_tdata[CNT_W-1:0],
                    s_tdata[CNT_W+ALIGN_W-1:CNT_W],
                    s_tdata[CNT_W+ALIGN_W+UNIT_W-1:CNT_W+ALIGN_W]));
            end
        end
        mismatch_count     <= errs;
        grants_outstanding <= expected_grants.size();
    end

endmodule

// ===== bench/bitmap_aligned_allocator_core_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_aligned_allocator_core_test
// Drives allocate and free requests into the allocator: a directed opening
// over the field extremes and special cases, then random well-formed
// alloc/free traffic mixed with noise, under random sender gaps and receiver
// stalls. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bitmap_aligned_allocator_core_test;
    import bmaa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 1530;
    localparam int LIVE_UNIT_CAP = 384;      // keeps first-fit scans short
    localparam int DRAIN_CYCLES  = 64;
    // worst alloc walks every used unit; even ~1550 such items
    // plus stalls and gaps stay well below this
    localparam int CYCLE_LIMIT   = 100_000_000;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

    // a run the stimulus knows to be allocated, kept so it can be freed again
    typedef struct packed {
        logic [UNIT_W-1:0] offset;
        logic [CNT_W-1:0]  count;
    } live_run_t;

    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] count;
    } sent_req_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // unit_count[10:0], align_log2[14:11],
                                  // free_offset[26:15], zero pad [31:27]
    logic [0:0]  s_tuser  = '0;   // cmd[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // status[1:0], granted_offset[13:2],
                                  // zero pad [15:14]

    int          mismatch_count;
    int          grants_outstanding;
    int          cycle_count = 0;

    live_run_t   live_runs[$];
    int          live_units = 0;
    sent_req_t   sent_reqs[$];
    int          burst_left = 0;

    rx_mode_t    rx_mode  = RX_ALWAYS;
    int          rx_phase = 0;

    bitmap_aligned_allocator_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bmaa_grant_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .mismatch_count     (mismatch_count),
        .grants_outstanding (grants_outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: switches at random between stall patterns, with
    // always-ready stretches among them.
    always @(posedge aclk) begin
        if (rx_phase == 0) begin
            rx_mode  <= rx_mode_t'($urandom_range(0, 3));
            rx_phase <= $urandom_range(50, 600);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        case (rx_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= (cycle_count % 5) != 0;
        endcase
    end

    // Learn granted offsets from the result stream, so that later frees name
    // runs that really are allocated.
    always @(posedge aclk) begin
        sent_req_t req;
        live_run_t run;
        if (aresetn && m_tvalid && m_tready && sent_reqs.size() != 0) begin
            req = sent_reqs.pop_front();
            if (req.cmd == CMD_ALLOC && m_tdata[STATUS_W-1:0] == ST_OK) begin
                run.offset = m_tdata[STATUS_W+UNIT_W-1:STATUS_W];
                run.count  = req.count;
                live_runs.push_back(run);
                live_units += int'(req.count);
            end
        end
    end

    // Mostly short bursts, sometimes long back-to-back stretches.
    function automatic int burst_length();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                           : $urandom_range(1, 6);
    endfunction

    // Present one item and hold it until accepted. Called at a rising edge.
    // valid only drops when a gap starts, so it is never lowered and raised
    // in the same step.
    task automatic send_request(input logic cmd, input int count,
                                input int align, input int foff);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, 12'(foff), 4'(align), 11'(count)};
        do @(posedge aclk); while (!s_tready);
        sent_reqs.push_back({cmd, 11'(count)});
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            burst_left = burst_length();
        end
    endtask

    initial begin
        int        pick;
        int        k;
        int        cnt;
        live_run_t run;

        burst_left = burst_length();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed opening ----
        // zero count and over-long runs are rejected for both commands
        send_request(CMD_ALLOC, 0,    0,  0);
        send_request(CMD_ALLOC, 2047, 15, 4095);
        send_request(CMD_FREE,  0,    0,  0);
        send_request(CMD_FREE,  1025, 0,  0);
        // smallest run lands at offset 0; free_offset is ignored on alloc
        send_request(CMD_ALLOC, 1,    0,  4095);
        // alignment beyond the heap only tries offset 0, which is taken
        send_request(CMD_ALLOC, 1,    15, 0);
        // fill the heap with largest runs: 1024, then 2048 and 3072 after
        // walking past the used units one by one
        send_request(CMD_ALLOC, 1024, 10, 0);
        send_request(CMD_ALLOC, 1024, 0,  0);
        send_request(CMD_ALLOC, 1024, 0,  0);
        // heap full up to the last run: no space
        send_request(CMD_ALLOC, 1024, 0,  0);
        // free of the last unit, a free running past the heap end,
        // a free ending exactly at the heap end, then a double free
        send_request(CMD_FREE,  1,    0,  4095);
        send_request(CMD_FREE,  2,    0,  4095);
        send_request(CMD_FREE,  1024, 0,  3072);
        send_request(CMD_FREE,  1024, 5,  3072);
        // aligned to 1024: lands at 3072; aligned to 2048: nothing fits
        send_request(CMD_ALLOC, 1,    10, 0);
        send_request(CMD_ALLOC, 1,    11, 0);
        // release offset 0, then the large alignment succeeds there
        send_request(CMD_FREE,  1,    0,  0);
        send_request(CMD_ALLOC, 1,    15, 0);
        // clear the whole heap for the random part
        send_request(CMD_FREE,  1024, 0,  0);
        send_request(CMD_FREE,  1024, 0,  1024);
        send_request(CMD_FREE,  1024, 0,  2048);
        send_request(CMD_FREE,  1024, 0,  3072);

        // let the opening drain so the random part starts on an empty heap
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (grants_outstanding != 0);
        live_runs.delete();
        live_units = 0;
        burst_left = burst_length();

        // ---- random traffic ----
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // noise: any field value, bad ranges and double frees included
                send_request(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                             $urandom_range(0, 15), $urandom_range(0, 4095));
            end else if (live_runs.size() != 0 &&
                         (live_units > LIVE_UNIT_CAP || pick < 50)) begin
                // give back a run we hold
                k   = $urandom_range(0, live_runs.size() - 1);
                run = live_runs[k];
                live_runs.delete(k);
                live_units -= int'(run.count);
                send_request(CMD_FREE, int'(run.count), $urandom_range(0, 15),
                             int'(run.offset));
            end else begin
                k = $urandom_range(0, 49);
                if (k == 0) begin
                    cnt = $urandom_range(512, MAX_RUN);
                end else if (k < 6) begin
                    cnt = $urandom_range(65, 256);
                end else begin
                    cnt = $urandom_range(1, 64);
                end
                send_request(CMD_ALLOC, cnt, $urandom_range(0, 10),
                             $urandom_range(0, 4095));
            end
        end

        // ---- drain and verdict ----
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (grants_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && grants_outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bmaa_pkg.sv
rtl/bmaa_ram.sv
rtl/bmaa_word_unit.sv
rtl/bitmap_aligned_allocator_core.sv
bench/bmaa_grant_checker.sv
bench/bitmap_aligned_allocator_core_test.sv
